/* design/route_table_first_match_defines.svh */
// Assertion macros for the route table block.
// Expects clk and arst_n in the scope of each use.
`ifndef ROUTE_TABLE_FIRST_MATCH_DEFINES_SVH
`define ROUTE_TABLE_FIRST_MATCH_DEFINES_SVH

// holds whenever the condition is seen in the same cycle
`define RTFM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("route table check failed");

// holds in the cycle after the condition
`define RTFM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("route table check failed");

`endif

/* design/rtfm_pkg.sv */
// Shared types, codes and the prefix mask function of the route table.
// No dependencies.
package rtfm_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_MARK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMATCH = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADIDX  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_RMW,
		S_DONE
	} state_t;

	localparam logic [2:0] REG_DIRECT = 3'd0;

	typedef struct packed {
		logic [31:0] net;
		logic [5:0]  prefix;
		logic [31:0] gw;
		logic [15:0] distance;
		logic [7:0]  reach;
		logic        dir;
	} entry_t;

	typedef struct packed {
		logic   act;
		mode_t  mode;
		logic   casc;
		logic [5:0] idx;
		logic   found;
		logic [5:0] mi;
		entry_t ent;
	} tok_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] p);
		logic [31:0] m;
		if (p == 6'd0) begin
			m = 32'd0;
		end else if (p >= 6'd32) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = ~(32'hFFFF_FFFF >> p);
		end
		return m;
	endfunction

endpackage

/* design/rtfm_cell.sv */
// One table slot of the route table and its stage of the scan chain.
// Depends on rtfm_pkg.
module rtfm_cell import rtfm_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int SLOT  = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tok_t                       tok_in,
	output tok_t                       tok_out,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic [6:0]                 direct_entries,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_idx,
	input  entry_t                     wr_data
);
	localparam int IW = $clog2(DEPTH);

	entry_t ent_q;
	tok_t   tok_q;
	tok_t   t;
	logic   zero_reach;
	logic   in_tab;
	logic   is_last;
	logic   is_idx;
	logic   past_direct;

	assign in_tab      = 32'(SLOT) < 32'(count);
	assign is_last     = (32'(SLOT) + 32'd1) == 32'(count);
	assign is_idx      = 32'(tok_in.idx) == 32'(SLOT);
	assign past_direct = 32'(SLOT) >= 32'(direct_entries);

	always_comb begin
		t = tok_in;
		zero_reach = 1'b0;
		if (tok_in.act) begin
			unique case (tok_in.mode)
				MODE_LOOKUP: begin
					if (!tok_in.found && in_tab &&
						ent_q.net == (tok_in.ent.net & prefix_mask(ent_q.prefix))) begin
						t.found = 1'b1;
						t.mi    = 6'(SLOT);
						t.ent   = ent_q;
					end
				end
				MODE_REMOVE: begin
					if (is_last) begin
						t.ent = ent_q;
					end
				end
				MODE_MARK: begin
					if (is_idx) begin
						zero_reach   = 1'b1;
						t.ent.net    = ent_q.net;
						t.ent.prefix = ent_q.prefix;
					end else if (tok_in.casc && in_tab && past_direct &&
						tok_in.ent.net == (ent_q.gw & prefix_mask(tok_in.ent.prefix))) begin
						zero_reach = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= t;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IW'(SLOT)) begin
			ent_q <= wr_data;
		end else if (zero_reach) begin
			ent_q.reach <= 8'd0;
		end
	end

	assign tok_out = tok_q;

endmodule

/* design/route_table_first_match.sv */
// Route table of DEPTH slots held in a row of cells; a scan word walks the row one
// cell per cycle. Insert writes the next free slot directly; lookup, mark unreachable
// and remove walk the cell chain, and remove then moves the last entry into the freed
// slot. Depends on rtfm_pkg, rtfm_cell and route_table_first_match_defines.svh.
`include "route_table_first_match_defines.svh"
module route_table_first_match import rtfm_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] ip_addr,
	input  logic [5:0]  prefix_bits,
	input  logic [31:0] gateway_addr,
	input  logic [15:0] hop_distance,
	input  logic [7:0]  reach_count,
	input  logic        is_direct,
	input  logic [5:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  match_index,
	output logic [6:0]  count_now,
	output logic [15:0] match_distance,
	output logic [7:0]  match_reach,
	output logic [31:0] match_gateway,
	output logic        match_direct,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = $clog2(DEPTH);

	state_t  state_q, state_d;
	logic [CW-1:0] count_q;
	logic [6:0]    de_q;
	mode_t   mode_q;
	logic [5:0] idx_q;
	entry_t  ins_q;
	entry_t  rm_q;
	status_t res_status_q;
	logic [5:0] res_mi_q;
	entry_t  res_ent_q;
	tok_t    launch_q;
	tok_t    tok [DEPTH+1];
	logic    accept;
	logic    out_free;
	logic    wr_en;
	logic [IW-1:0] wr_idx;
	entry_t  wr_data;
	logic    full;
	logic    bad_idx;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_DIRECT) ? {25'd0, de_q} : 32'd0;
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign full     = count_q == CW'(DEPTH);
	assign bad_idx  = 32'(entry_index) >= 32'(count_q);

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_idx  = count_q[IW-1:0];
		wr_data = ins_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (mode_t'(mode) == MODE_INSERT) begin
						state_d = full ? S_DONE : S_INS;
					end else if (mode_t'(mode) == MODE_LOOKUP) begin
						state_d = S_SCAN;
					end else begin
						state_d = bad_idx ? S_DONE : S_SCAN;
					end
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (tok[DEPTH].act) begin
					state_d = (mode_q == MODE_REMOVE) ? S_RMW : S_DONE;
				end
			end
			S_RMW: begin
				wr_en   = 1'b1;
				wr_idx  = IW'(idx_q);
				wr_data = rm_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			de_q         <= 7'd0;
			out_valid    <= 1'b0;
			launch_q     <= '0;
		end else begin
			state_q      <= state_d;
			launch_q.act <= accept && (mode_t'(mode) == MODE_LOOKUP ||
				(mode_t'(mode) != MODE_INSERT && !bad_idx));
			if (accept) begin
				launch_q.mode  <= mode_t'(mode);
				launch_q.casc  <= 32'(entry_index) < 32'(de_q);
				launch_q.idx   <= entry_index;
				launch_q.found <= 1'b0;
				launch_q.mi    <= 6'd0;
				launch_q.ent   <= '{net: ip_addr, prefix: 6'd0, gw: 32'd0,
					distance: 16'd0, reach: 8'd0, dir: 1'b0};
			end
			if (psel && penable && pwrite && paddr == REG_DIRECT) begin
				de_q <= pwdata[6:0];
			end
			if (state_q == S_INS) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_RMW) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q        <= mode_t'(mode);
			idx_q         <= entry_index;
			ins_q         <= '{net: ip_addr, prefix: prefix_bits, gw: gateway_addr,
				distance: hop_distance, reach: reach_count, dir: is_direct};
			res_mi_q      <= 6'd0;
			res_ent_q     <= '0;
			priority if (mode_t'(mode) == MODE_INSERT) begin
				res_status_q <= full ? ST_FULL : ST_OK;
			end else if (mode_t'(mode) == MODE_LOOKUP) begin
				res_status_q <= ST_NOMATCH;
			end else begin
				res_status_q <= bad_idx ? ST_BADIDX : ST_OK;
			end
		end
		if (state_q == S_SCAN && tok[DEPTH].act) begin
			rm_q <= tok[DEPTH].ent;
			if (mode_q == MODE_LOOKUP && tok[DEPTH].found) begin
				res_status_q <= ST_OK;
				res_mi_q     <= tok[DEPTH].mi;
				res_ent_q    <= tok[DEPTH].ent;
			end
		end
		if (state_q == S_DONE && out_free) begin
			status         <= res_status_q;
			match_index    <= res_mi_q;
			count_now      <= 7'(count_q);
			match_distance <= res_ent_q.distance;
			match_reach    <= res_ent_q.reach;
			match_gateway  <= res_ent_q.gw;
			match_direct   <= res_ent_q.dir;
		end
	end

	assign tok[0] = launch_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		rtfm_cell #(.DEPTH(DEPTH), .SLOT(g)) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.tok_in        (tok[g]),
			.tok_out       (tok[g+1]),
			.count         (count_q),
			.direct_entries(de_q),
			.wr_en         (wr_en),
			.wr_idx        (wr_idx),
			.wr_data       (wr_data)
		);
	end

	`RTFM_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_q) <= 32'(DEPTH))
	`RTFM_ASSERT_NEXT(a_accept_busy, accept, !in_ready)
	`RTFM_ASSERT_NEXT(a_done_emits, state_q == S_DONE && out_free, out_valid)
	`RTFM_ASSERT_SAME(a_exit_in_scan, tok[DEPTH].act, state_q == S_SCAN)

endmodule

/* tb/rtfm_route_checker.sv */
// Watches the route table ports, keeps its own copy of the table and the direct count,
// and compares each reply word with the predicted one. Depends on rtfm_pkg.
module rtfm_route_checker import rtfm_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] ip_addr,
	input  logic [5:0]  prefix_bits,
	input  logic [31:0] gateway_addr,
	input  logic [15:0] hop_distance,
	input  logic [7:0]  reach_count,
	input  logic        is_direct,
	input  logic [5:0]  entry_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [5:0]  match_index,
	input  logic [6:0]  count_now,
	input  logic [15:0] match_distance,
	input  logic [7:0]  match_reach,
	input  logic [31:0] match_gateway,
	input  logic        match_direct,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t     st;
		logic [5:0]  idx;
		logic [6:0]  cnt;
		logic [15:0] distance;
		logic [7:0]  reach;
		logic [31:0] gw;
		logic        dir;
	} route_reply_t;

	logic [31:0] tbl_net [DEPTH];
	logic [5:0]  tbl_prefix [DEPTH];
	logic [31:0] tbl_gw [DEPTH];
	logic [15:0] tbl_dist [DEPTH];
	logic [7:0]  tbl_reach [DEPTH];
	logic        tbl_dir [DEPTH];
	int          route_count;
	int          direct_limit;
	route_reply_t expected_replies [$];

	assign pending = expected_replies.size();

	function automatic logic [31:0] net_mask(input logic [5:0] p);
		logic [31:0] ones;
		ones = '1;
		if (p == 0)
			return 32'd0;
		if (p >= 32)
			return ones;
		return ones << (32 - p);
	endfunction

	function automatic route_reply_t apply_route_op();
		route_reply_t r;
		int last;
		int k;
		r = '0;
		r.st = ST_OK;
		case (mode_t'(mode))
			MODE_INSERT: begin
				if (route_count >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					tbl_net[route_count] = ip_addr;
					tbl_prefix[route_count] = prefix_bits;
					tbl_gw[route_count] = gateway_addr;
					tbl_dist[route_count] = hop_distance;
					tbl_reach[route_count] = reach_count;
					tbl_dir[route_count] = is_direct;
					route_count++;
				end
			end
			MODE_REMOVE: begin
				if (entry_index >= route_count) begin
					r.st = ST_BADIDX;
				end else begin
					last = route_count - 1;
					tbl_net[entry_index] = tbl_net[last];
					tbl_prefix[entry_index] = tbl_prefix[last];
					tbl_gw[entry_index] = tbl_gw[last];
					tbl_dist[entry_index] = tbl_dist[last];
					tbl_reach[entry_index] = tbl_reach[last];
					tbl_dir[entry_index] = tbl_dir[last];
					route_count = last;
				end
			end
			MODE_LOOKUP: begin
				r.st = ST_NOMATCH;
				for (k = 0; k < route_count; k++) begin
					if (tbl_net[k] == (ip_addr & net_mask(tbl_prefix[k]))) begin
						r.st = ST_OK;
						r.idx = k[5:0];
						r.distance = tbl_dist[k];
						r.reach = tbl_reach[k];
						r.gw = tbl_gw[k];
						r.dir = tbl_dir[k];
						break;
					end
				end
			end
			default: begin
				if (entry_index >= route_count) begin
					r.st = ST_BADIDX;
				end else begin
					tbl_reach[entry_index] = 8'd0;
					if (entry_index < direct_limit) begin
						for (k = direct_limit; k < route_count; k++)
							if (tbl_net[entry_index] ==
									(tbl_gw[k] & net_mask(tbl_prefix[entry_index])))
								tbl_reach[k] = 8'd0;
					end
				end
			end
		endcase
		r.cnt = route_count[6:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		route_count = 0;
		direct_limit = 0;
	end

	always @(posedge clk) begin
		route_reply_t w;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == (REG_DIRECT << 2))
				direct_limit = pwdata[6:0];
			if (in_valid && in_ready)
				expected_replies.push_back(apply_route_op());
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected word", status, 0);
				end else begin
					w = expected_replies.pop_front();
					if (status !== w.st) report_mismatch("status", status, w.st);
					if (match_index !== w.idx) report_mismatch("match_index", match_index, w.idx);
					if (count_now !== w.cnt) report_mismatch("count_now", count_now, w.cnt);
					if (match_distance !== w.distance)
						report_mismatch("match_distance", match_distance, w.distance);
					if (match_reach !== w.reach) report_mismatch("match_reach", match_reach, w.reach);
					if (match_gateway !== w.gw) report_mismatch("match_gateway", match_gateway, w.gw);
					if (match_direct !== w.dir) report_mismatch("match_direct", match_direct, w.dir);
				end
			end
		end
	end

endmodule

/* tb/tb_route_table_first_match.sv */
// Top of the route table testbench: clock, reset, register writes and stimulus words.
// Depends on rtfm_pkg, route_table_first_match and rtfm_route_checker.
module tb_route_table_first_match;
	import rtfm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE = DEPTH + 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_LOOKUP;
	logic [31:0] ip_addr = '0;
	logic [5:0]  prefix_bits = '0;
	logic [31:0] gateway_addr = '0;
	logic [15:0] hop_distance = '0;
	logic [7:0]  reach_count = '0;
	logic        is_direct = 1'b0;
	logic [5:0]  entry_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [5:0]  match_index;
	logic [6:0]  count_now;
	logic [15:0] match_distance;
	logic [7:0]  match_reach;
	logic [31:0] match_gateway;
	logic        match_direct;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          insert_pct = 35;
	int          remove_pct = 15;

	route_table_first_match #(.DEPTH(DEPTH)) uut (.*);
	rtfm_route_checker #(.DEPTH(DEPTH)) chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic write_direct(input logic [6:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DIRECT << 2;
		pwdata <= {25'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// hold the word until taken; return at a falling edge with valid still high
	task automatic send_word(input mode_t m, input logic [31:0] ip, input logic [5:0] p,
			input logic [31:0] gw, input logic [15:0] d, input logic [7:0] rc,
			input logic dr, input logic [5:0] ix);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		ip_addr <= ip;
		prefix_bits <= p;
		gateway_addr <= gw;
		hop_distance <= d;
		reach_count <= rc;
		is_direct <= dr;
		entry_index <= ix;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] pool_addr();
		if ($urandom_range(9) < 8)
			return {8'd10, 6'd0, 2'($urandom_range(3)), 16'($urandom)};
		return $urandom;
	endfunction

	task automatic random_word();
		int r;
		logic [5:0] p;
		logic [31:0] a;
		logic [31:0] ones;
		r = $urandom_range(99);
		ones = '1;
		p = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8, 24));
		a = pool_addr();
		if ($urandom_range(9) < 8 && p != 0 && p < 32)
			a = a & (ones << (32 - p));
		else if ($urandom_range(9) < 8 && p == 0)
			a = 32'd0;
		if (r < insert_pct)
			send_word(MODE_INSERT, a, p, pool_addr(), 16'($urandom), 8'($urandom),
				1'($urandom), 6'($urandom));
		else if (r < insert_pct + remove_pct)
			send_word(MODE_REMOVE, $urandom, 6'($urandom), $urandom, 16'($urandom),
				8'($urandom), 1'($urandom),
				$urandom_range(1) ? 6'($urandom) : 6'($urandom_range(15)));
		else if (r < 85)
			send_word(MODE_LOOKUP, pool_addr(), 6'($urandom), $urandom, 16'($urandom),
				8'($urandom), 1'($urandom), 6'($urandom));
		else
			send_word(MODE_MARK, $urandom, 6'($urandom), $urandom, 16'($urandom),
				8'($urandom), 1'($urandom), $urandom_range(1) ? 6'($urandom)
				: 6'($urandom_range(15)));
	endtask

	initial begin
		int ph;
		int n;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_direct(7'd2);

		send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_REMOVE, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_MARK, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd63);
		send_word(MODE_INSERT, 32'h0A00_0000, 6'd8, 32'd0, 16'hFFFF, 8'hFF, 1'b1, 6'd63);
		send_word(MODE_INSERT, 32'h0A01_0000, 6'd16, 32'hFFFF_FFFF, 16'd0, 8'd1, 1'b1, 6'd0);
		send_word(MODE_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0A00_0005, 16'd7, 8'd9, 1'b0, 6'd0);
		send_word(MODE_INSERT, 32'hC0A8_0101, 6'd32, 32'h0A01_0203, 16'd3, 8'd4, 1'b0, 6'd0);
		send_word(MODE_INSERT, 32'd0, 6'd0, 32'h0B00_0001, 16'd1, 8'd2, 1'b0, 6'd0);
		send_word(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_LOOKUP, 32'hC0A8_0101, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_LOOKUP, 32'h0A01_9999, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_LOOKUP, 32'h0B00_0001, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_MARK, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_MARK, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd3);
		send_word(MODE_LOOKUP, 32'h0A00_0005, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		send_word(MODE_REMOVE, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd1);
		send_word(MODE_REMOVE, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd3);
		send_word(MODE_REMOVE, 32'd0, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd5);
		send_word(MODE_LOOKUP, 32'h1234_5678, 6'd0, 32'd0, 16'd0, 8'd0, 1'b0, 6'd0);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_direct(7'd0);
				1: write_direct(7'd64);
				2: write_direct(7'd8);
				3: write_direct(7'($urandom_range(1, 20)));
				4: write_direct(7'd1);
				default: write_direct(7'($urandom_range(64)));
			endcase
			gap_pct = (ph == 1) ? 77 : (ph == 3) ? 38 : 0;
			stall_pct = (ph == 2) ? 77 : (ph == 3) ? 38 : 0;
			insert_pct = ph[0] ? 25 : 45;
			remove_pct = ph[0] ? 35 : 15;
			for (n = 0; n < 305; n++)
				random_word();
			drain();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
